FILE: rtl/core/bcf_pkg.sv
package bcf_pkg;

   localparam int TAPS_DEFAULT = 64;

   localparam int SAMPLE_W = 16;
   localparam int INDEX_W  = 6;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   localparam int ROUND_BIAS = 16384;
   localparam int FRAC_BITS  = 15;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_ROUND
   } bcf_state_type;

endpackage

FILE: rtl/core/block_convolution_fir_unit.sv
// channel | direction | tdata (low bit up)                         | tuser
// req     | in        | sample_in[15:0] coef_index[21:16]          | op[0]
//         |           | coef_value[37:22] zero[39:38]              |
// rsp     | out       | sample_out[15:0]                           | saturated[0]
//
// Sample beat: after acceptance the taps are swept, the read and product registers
// drain, then the sum is rounded; beats are accepted only in idle. A coefficient beat is
// written on acceptance. After reset a clearing pass zeroes both memories, req_tready low.
// The result register holds a finished sample while the next beat is accepted;
// a stalled rsp side holds the block in its round step until the result is taken.
module block_convolution_fir_unit #(
   parameter int TAPS = bcf_pkg::TAPS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // sample_in, coef_index, coef_value, zero pad
   input  logic [bcf_pkg::REQ_DATA_W-1:0]  req_tdata,
   // op
   input  logic [0:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // sample_out
   output logic [bcf_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // saturated
   output logic [0:0]                      rsp_tuser
);
   import bcf_pkg::*;

   localparam int PTR_W = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int ACC_W = 2 * SAMPLE_W + 1 + PTR_W;
   localparam int CIW   = ((PTR_W > INDEX_W) ? PTR_W : INDEX_W) + 1;
   localparam logic [PTR_W-1:0] LAST = PTR_W'(TAPS - 1);
   localparam logic signed [ACC_W:0] MAX_V = (ACC_W+1)'(32767);
   localparam logic signed [ACC_W:0] MIN_V = -(ACC_W+1)'(32768);

   bcf_state_type state_ff, state_in;
   logic [PTR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] k_ff, k_in;
   logic [PTR_W-1:0] idx_ff, idx_in;
   logic             rd_v_ff;
   logic             prod_v_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_data_ff;
   logic             rsp_sat_ff;

   logic signed [SAMPLE_W-1:0] dly_mem [TAPS];
   logic signed [SAMPLE_W-1:0] coef_mem [TAPS];
   logic signed [SAMPLE_W-1:0] dly_q, coef_q;
   logic signed [2*SAMPLE_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]      acc_ff;

   logic                   accept, in_range, acc_clr, out_load, do_mac;
   logic                   dly_we, coef_we;
   logic [PTR_W-1:0]       dly_waddr, coef_waddr;
   logic signed [SAMPLE_W-1:0] dly_wdata, coef_wdata;
   logic [CIW-1:0]         ci_ext;
   logic                   op;
   logic signed [SAMPLE_W-1:0] sample_in, coef_value;
   logic [INDEX_W-1:0]     coef_index;
   logic signed [ACC_W:0]  biased, rounded;
   logic                   sat_hi, sat_lo;
   logic [PTR_W-1:0]       wp_next;

   assign op         = req_tuser[0];
   assign sample_in  = req_tdata[15:0];
   assign coef_index = req_tdata[21:16];
   assign coef_value = req_tdata[37:22];
   assign ci_ext     = CIW'(coef_index);
   assign in_range   = ci_ext < CIW'(TAPS);
   assign accept     = req_tvalid && req_tready;
   assign wp_next    = (wp_ff == LAST) ? '0 : wp_ff + 1'b1;

   assign biased  = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(ROUND_BIAS);
   assign rounded = biased >>> FRAC_BITS;
   assign sat_hi  = rounded > MAX_V;
   assign sat_lo  = rounded < MIN_V;

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      wp_in        = wp_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      acc_clr      = 1'b0;
      out_load     = 1'b0;
      do_mac       = 1'b0;
      req_tready   = 1'b0;
      dly_we       = 1'b0;
      coef_we      = 1'b0;
      dly_waddr    = wp_ff;
      coef_waddr   = ci_ext[PTR_W-1:0];
      dly_wdata    = sample_in;
      coef_wdata   = coef_value;
      case (state_ff)
         ST_CLEAR: begin
            dly_we     = 1'b1;
            coef_we    = 1'b1;
            dly_waddr  = clr_cnt_ff;
            coef_waddr = clr_cnt_ff;
            dly_wdata  = '0;
            coef_wdata = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               if (op == OP_LOAD) begin
                  coef_we = in_range;
               end else begin
                  dly_we   = 1'b1;
                  acc_clr  = 1'b1;
                  k_in     = '0;
                  idx_in   = wp_ff;
                  state_in = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            do_mac = 1'b1;
            k_in   = k_ff + 1'b1;
            idx_in = (idx_ff == '0) ? LAST : idx_ff - 1'b1;
            if (k_ff == LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_v_ff && !prod_v_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               wp_in    = wp_next;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         wp_ff        <= '0;
         k_ff         <= '0;
         idx_ff       <= '0;
         rd_v_ff      <= 1'b0;
         prod_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         wp_ff        <= wp_in;
         k_ff         <= k_in;
         idx_ff       <= idx_in;
         rd_v_ff      <= do_mac;
         prod_v_ff    <= rd_v_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // tap memories, registered read
   always_ff @(posedge clock) begin
      if (dly_we) begin
         dly_mem[dly_waddr] <= dly_wdata;
      end
      dly_q <= dly_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= coef_wdata;
      end
      coef_q <= coef_mem[k_ff];
   end

   always_ff @(posedge clock) begin
      prod_ff <= coef_q * dly_q;
      if (acc_clr) begin
         acc_ff <= '0;
      end else if (prod_v_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (out_load) begin
         rsp_sat_ff <= sat_hi || sat_lo;
         if (sat_hi) begin
            rsp_data_ff <= 16'h7fff;
         end else if (sat_lo) begin
            rsp_data_ff <= 16'h8000;
         end else begin
            rsp_data_ff <= rounded[15:0];
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_sat_ff;

`ifndef SYNTHESIS
   a_wp_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, wp_ff} < (PTR_W+1)'(TAPS))
      else $error("write pointer out of range");

   a_sample_starts_mac: assert property (@(posedge clock) disable iff (reset)
      (accept && op == OP_SAMPLE) |=> (state_ff == ST_MAC && k_ff == '0))
      else $error("sample beat did not start tap sweep at tap zero");

   a_round_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (!rd_v_ff && !prod_v_ff))
      else $error("rounding while products still in flight");

   a_pipe_only_in_sweep: assert property (@(posedge clock) disable iff (reset)
      prod_v_ff |-> (state_ff == ST_MAC || state_ff == ST_DRAIN))
      else $error("product valid outside tap sweep");

   a_wp_advance: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (wp_ff == $past(wp_next) && rsp_valid_ff))
      else $error("result load did not advance write pointer");
`endif

endmodule
